>>> rtl/pnp_pkg.sv
// Package for the prefixed number parser: state and result types, phase codes,
// radix codes and the ASCII constants used by the parse logic.
// No dependencies.
`default_nettype none

package pnp_pkg;

    // Parse phase of the open token.
    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_ZERO = 3'd1,
        PH_DEC  = 3'd2,
        PH_HEX  = 3'd3,
        PH_BIN  = 3'd4
    } t_phase;

    // Radix codes carried by a result.
    localparam logic [1:0] RADIX_DEC = 2'd0;
    localparam logic [1:0] RADIX_HEX = 2'd1;
    localparam logic [1:0] RADIX_BIN = 2'd2;

    // ASCII codes.
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_ONE     = 8'h31;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_MINUS   = 8'h2d;
    localparam logic [7:0] CH_UP_A    = 8'h41;
    localparam logic [7:0] CH_UP_F    = 8'h46;
    localparam logic [7:0] CH_LO_A    = 8'h61;
    localparam logic [7:0] CH_LO_F    = 8'h66;
    localparam logic [7:0] CH_UP_X    = 8'h58;
    localparam logic [7:0] CH_LO_X    = 8'h78;
    localparam logic [7:0] CH_UP_B    = 8'h42;
    localparam logic [7:0] CH_LO_B    = 8'h62;
    localparam logic [7:0] UP_A_BASE  = 8'd55;   // 'A' - 10
    localparam logic [7:0] LO_A_BASE  = 8'd87;   // 'a' - 10
    localparam logic [7:0] COUNT_MAX  = 8'd255;

    // Token state carried from one character to the next.
    typedef struct packed {
        t_phase      phase;
        logic [31:0] accum;
        logic        negative;
        logic [7:0]  count;
    } t_state;

    // One result item.
    typedef struct packed {
        logic signed [31:0] value;
        logic [7:0]         consumed;
        logic               found;
        logic [1:0]         radix;
        logic [7:0]         stop_char;
    } t_result;

endpackage

`default_nettype wire

>>> rtl/pnp_step.sv
// Single-character parse step: next token state, and the result when the
// character ends the token. Purely combinational.
// Depends on pnp_pkg.
`default_nettype none

module pnp_step (
    input  wire pnp_pkg::t_state  i_state,
    input  wire logic [7:0]       i_ch,
    input  wire logic             i_first,
    output pnp_pkg::t_state       o_next,
    output logic                  o_emit,
    output pnp_pkg::t_result      o_result
);

    logic       is_dec;
    logic       is_up_hex;
    logic       is_lo_hex;
    logic       is_bin;
    logic       is_x;
    logic       is_b;
    logic [3:0] dec_digit;
    logic [3:0] hex_digit;
    logic [7:0] count_inc;
    logic [31:0] dec_accum;

    // Character classes and digit values.
    assign is_dec    = (i_ch >= pnp_pkg::CH_ZERO) && (i_ch <= pnp_pkg::CH_NINE);
    assign is_up_hex = (i_ch >= pnp_pkg::CH_UP_A) && (i_ch <= pnp_pkg::CH_UP_F);
    assign is_lo_hex = (i_ch >= pnp_pkg::CH_LO_A) && (i_ch <= pnp_pkg::CH_LO_F);
    assign is_bin    = (i_ch == pnp_pkg::CH_ZERO) || (i_ch == pnp_pkg::CH_ONE);
    assign is_x      = (i_ch == pnp_pkg::CH_UP_X) || (i_ch == pnp_pkg::CH_LO_X);
    assign is_b      = (i_ch == pnp_pkg::CH_UP_B) || (i_ch == pnp_pkg::CH_LO_B);
    assign dec_digit = 4'(i_ch - pnp_pkg::CH_ZERO);

    always_comb begin
        if (is_up_hex) begin
            hex_digit = 4'(i_ch - pnp_pkg::UP_A_BASE);
        end else if (is_lo_hex) begin
            hex_digit = 4'(i_ch - pnp_pkg::LO_A_BASE);
        end else begin
            hex_digit = dec_digit;
        end
    end

    // Saturating character count and the times-ten accumulate.
    assign count_inc = (i_state.count == pnp_pkg::COUNT_MAX) ? i_state.count
                                                               : i_state.count + 8'd1;
    assign dec_accum = (i_state.accum << 3) + (i_state.accum << 1) + 32'(dec_digit);

    // Next token state.
    always_comb begin
        o_next = i_state;
        if (i_first) begin
            o_next.accum    = '0;
            o_next.negative = 1'b0;
            o_next.count    = '0;
            o_next.phase    = pnp_pkg::PH_IDLE;
            if (i_ch == pnp_pkg::CH_ZERO) begin
                o_next.count = 8'd1;
                o_next.phase = pnp_pkg::PH_ZERO;
            end else if (i_ch == pnp_pkg::CH_MINUS) begin
                o_next.negative = 1'b1;
                o_next.count    = 8'd1;
                o_next.phase    = pnp_pkg::PH_DEC;
            end else if (is_dec) begin
                o_next.accum = 32'(dec_digit);
                o_next.count = 8'd1;
                o_next.phase = pnp_pkg::PH_DEC;
            end
        end else begin
            unique case (i_state.phase)
                pnp_pkg::PH_ZERO: begin
                    if (is_x) begin
                        o_next.count = count_inc;
                        o_next.phase = pnp_pkg::PH_HEX;
                    end else if (is_b) begin
                        o_next.count = count_inc;
                        o_next.phase = pnp_pkg::PH_BIN;
                    end else if (is_dec) begin
                        o_next.accum = dec_accum;
                        o_next.count = count_inc;
                        o_next.phase = pnp_pkg::PH_DEC;
                    end else begin
                        o_next.phase = pnp_pkg::PH_IDLE;
                    end
                end
                pnp_pkg::PH_DEC: begin
                    if (is_dec) begin
                        o_next.accum = dec_accum;
                        o_next.count = count_inc;
                    end else begin
                        o_next.phase = pnp_pkg::PH_IDLE;
                    end
                end
                pnp_pkg::PH_HEX: begin
                    if (is_dec || is_up_hex || is_lo_hex) begin
                        o_next.accum = {i_state.accum[27:0], hex_digit};
                        o_next.count = count_inc;
                    end else begin
                        o_next.phase = pnp_pkg::PH_IDLE;
                    end
                end
                pnp_pkg::PH_BIN: begin
                    if (is_bin) begin
                        o_next.accum = {i_state.accum[30:0], i_ch[0]};
                        o_next.count = count_inc;
                    end else begin
                        o_next.phase = pnp_pkg::PH_IDLE;
                    end
                end
                default: begin
                    o_next.phase = pnp_pkg::PH_IDLE;
                end
            endcase
        end
    end

    // Token end detection and the result fields.
    always_comb begin
        o_emit         = 1'b0;
        o_result.radix = pnp_pkg::RADIX_DEC;
        if (i_first) begin
            o_emit = !(is_dec || (i_ch == pnp_pkg::CH_MINUS));
        end else begin
            unique case (i_state.phase)
                pnp_pkg::PH_ZERO: o_emit = !(is_x || is_b || is_dec);
                pnp_pkg::PH_DEC:  o_emit = !is_dec;
                pnp_pkg::PH_HEX: begin
                    o_emit         = !(is_dec || is_up_hex || is_lo_hex);
                    o_result.radix = pnp_pkg::RADIX_HEX;
                end
                pnp_pkg::PH_BIN: begin
                    o_emit         = !is_bin;
                    o_result.radix = pnp_pkg::RADIX_BIN;
                end
                default: o_emit = 1'b0;
            endcase
        end

        // A token that ends on its first character consumed nothing.
        if (i_first) begin
            o_result.value    = '0;
            o_result.consumed = '0;
        end else begin
            o_result.value    = i_state.negative ? $signed(32'd0 - i_state.accum)
                                                 : $signed(i_state.accum);
            o_result.consumed = i_state.count;
        end
        o_result.found     = (o_result.consumed != 8'd0);
        o_result.stop_char = i_ch;
    end

endmodule

`default_nettype wire

>>> rtl/prefixed_number_parser.sv
// Top level of the prefixed number parser: input register, token state,
// result register and the valid/stall handshakes.
// Depends on pnp_pkg and pnp_step.
`default_nettype none

//  Channel  | Direction | Handshake         | Payload
//  ---------+-----------+-------------------+---------------------------------------
//  input    | in        | i_valid / o_stall | i_ch, i_first
//  result   | out       | o_valid / i_stall | o_value, o_consumed, o_found, o_radix,
//           |           |                   | o_stop_char
//
// One character is taken per cycle while o_stall is low. A character is held in the
// input register and parsed once the result register is free, and its result, if any,
// is registered. The rate is set by the combinational step between the input register
// and the token state; the times-ten add is the longest path.
// Reset (synchronous, active low) empties both registers and returns to idle.
// A stalled result holds the parse step; the input register still takes one more character if it is empty.

module prefixed_number_parser (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [7:0]         i_ch,
    input  wire logic               i_first,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic signed [31:0]      o_value,
    output logic [7:0]              o_consumed,
    output logic                    o_found,
    output logic [1:0]              o_radix,
    output logic [7:0]              o_stop_char
);

    logic             r_in_valid;
    logic [7:0]       r_ch;
    logic             r_first;
    pnp_pkg::t_state  r_state;
    pnp_pkg::t_state  n_state;
    logic             r_out_valid;
    pnp_pkg::t_result r_result;
    pnp_pkg::t_result step_result;
    logic             step_emit;
    logic             out_free;
    logic             advance;

    // The held character is parsed whenever the result register can take a result.
    assign out_free = !r_out_valid || !i_stall;
    assign advance  = r_in_valid && out_free;
    assign o_stall  = r_in_valid && !out_free;

    pnp_step u_step (
        .i_state  (r_state),
        .i_ch     (r_ch),
        .i_first  (r_first),
        .o_next   (n_state),
        .o_emit   (step_emit),
        .o_result (step_result)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
        if (!o_stall && i_valid) begin
            r_ch    <= i_ch;
            r_first <= i_first;
        end
    end

    // Token state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase    <= pnp_pkg::PH_IDLE;
            r_state.accum    <= '0;
            r_state.negative <= 1'b0;
            r_state.count    <= '0;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= advance && step_emit;
        end
        if (advance && step_emit) begin
            r_result <= step_result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_value     = r_result.value;
    assign o_consumed  = r_result.consumed;
    assign o_found     = r_result.found;
    assign o_radix     = r_result.radix;
    assign o_stop_char = r_result.stop_char;

    // A prefixed result always counts at least the two prefix characters.
    a_prefix_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_radix == pnp_pkg::RADIX_HEX || o_radix == pnp_pkg::RADIX_BIN))
        |-> (o_consumed >= 8'd2))
        else $error("prefixed result with fewer than two characters");

    // A result with nothing consumed is a zero decimal value.
    a_not_found_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_value == 32'sd0 && o_radix == pnp_pkg::RADIX_DEC))
        else $error("result without consumed characters is not zero");

    // Input stalls only while a character is held and the result register is stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (r_in_valid && o_valid && i_stall))
        else $error("input stalled without a blocked result");

    // Both registers come out of reset empty.
    a_reset_empty: assert property (@(posedge i_clk)
        (i_rst_n && $past(!i_rst_n)) |-> (!o_valid && !r_in_valid))
        else $error("registers not empty after reset");

endmodule

`default_nettype wire
